[rtl/cbrp_pkg.sv]
`timescale 1ns / 1ps

package cbrp_pkg;

  localparam logic [1:0] FUNC_RD  = 2'd0;
  localparam logic [1:0] FUNC_WR  = 2'd1;
  localparam logic [1:0] FUNC_DMA = 2'd2;

  localparam logic [2:0] ROUTE_INT  = 3'd0;
  localparam logic [2:0] ROUTE_PPU  = 3'd1;
  localparam logic [2:0] ROUTE_CART = 3'd2;
  localparam logic [2:0] ROUTE_OAM  = 3'd3;
  localparam logic [2:0] ROUTE_NONE = 3'd4;

  localparam logic [15:0] ADDR_OAM_DMA = 16'h4014;
  localparam logic [15:0] ADDR_PAD     = 16'h4016;
  localparam logic [15:0] PPU_BASE     = 16'h2000;
  localparam logic [7:0]  PAD_OPEN     = 8'h40;

  // Result of one transaction as it moves toward the output register.
  typedef struct packed {
    logic [7:0]  rdata;
    logic        use_ram;   // read_data comes from the RAM read port
    logic        dma_cap;   // RAM byte also feeds the DMA byte latch
    logic [2:0]  route;
    logic [15:0] daddr;
    logic [7:0]  dwdata;
    logic        dwrite;
    logic        busy;
    logic        done;
  } item_t;

endpackage

[rtl/cbrp_ram.sv]
`timescale 1ns / 1ps

module cbrp_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data until the next read so a stalled result keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cbrp_front.sv]
`timescale 1ns / 1ps

module cbrp_front #(
  parameter int RAM_BYTES = 2048,
  parameter int AW        = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           func_i,
  input  logic [15:0]          addr_i,
  input  logic [7:0]           wdata_i,
  input  logic [7:0]           buttons_i,
  input  logic [7:0]           dev_rdata_i,
  input  logic                 cap_i,
  input  logic [7:0]           ram_rdata_i,
  output logic                 clr_o,
  output cbrp_pkg::item_t      item_o,
  output logic                 ram_we_o,
  output logic [AW-1:0]        ram_waddr_o,
  output logic [7:0]           ram_wdata_o,
  output logic                 ram_re_o,
  output logic [AW-1:0]        ram_raddr_o
);

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic          strobe_q, strobe_d;
  logic [7:0]    shift_q, shift_d;
  logic          active_q, active_d;
  logic          wphase_q, wphase_d;
  logic [15:0]   src_q, src_d;
  logic [7:0]    byte_q, byte_d;
  logic          ext_q, ext_d;

  logic [15:0]   ra;
  logic          do_read, do_write, dma_rd, dma_wr;
  logic          ra_ram, ra_ppu, ra_io, wa_ram, wa_ppu, wa_io;
  logic [7:0]    pad_src, oam_byte;
  logic [15:0]   src_inc;
  cbrp_pkg::item_t it;

  // Fold a work RAM address onto the RAM size; the quotient stays below eight.
  function automatic logic [AW-1:0] ram_index(input logic [12:0] a);
    logic [15:0] r;
    r = {3'b000, a};
    for (int k = 2; k >= 0; k--) begin
      if (r >= 16'(RAM_BYTES << k)) begin
        r = r - 16'(RAM_BYTES << k);
      end
    end
    return r[AW-1:0];
  endfunction

  assign dma_rd   = (func_i == cbrp_pkg::FUNC_DMA) && active_q && !wphase_q;
  assign dma_wr   = (func_i == cbrp_pkg::FUNC_DMA) && active_q && wphase_q;
  assign do_read  = (func_i == cbrp_pkg::FUNC_RD) || dma_rd;
  assign do_write = (func_i == cbrp_pkg::FUNC_WR);
  assign ra       = (func_i == cbrp_pkg::FUNC_RD) ? addr_i : src_q;

  assign ra_ram = (ra[15:13] == 3'd0);
  assign ra_ppu = (ra[15:13] == 3'd1);
  assign ra_io  = (ra[15:5] == 11'h200);
  assign wa_ram = (addr_i[15:13] == 3'd0);
  assign wa_ppu = (addr_i[15:13] == 3'd1);
  assign wa_io  = (addr_i[15:5] == 11'h200);

  assign pad_src  = strobe_q ? buttons_i : shift_q;
  assign src_inc  = src_q + 16'd1;
  assign oam_byte = ext_q ? dev_rdata_i : (cap_i ? ram_rdata_i : byte_q);

  always_comb begin
    it        = '0;
    it.route  = cbrp_pkg::ROUTE_NONE;
    strobe_d  = strobe_q;
    shift_d   = shift_q;
    active_d  = active_q;
    wphase_d  = wphase_q;
    src_d     = src_q;
    byte_d    = cap_i ? ram_rdata_i : byte_q;
    ext_d     = ext_q;

    if (do_read) begin
      if (ra_ram) begin
        it.route   = cbrp_pkg::ROUTE_INT;
        it.use_ram = 1'b1;
      end else if (ra_ppu) begin
        it.route = cbrp_pkg::ROUTE_PPU;
        it.daddr = cbrp_pkg::PPU_BASE | {13'd0, ra[2:0]};
      end else if (ra_io) begin
        it.route = cbrp_pkg::ROUTE_INT;
        if (ra == cbrp_pkg::ADDR_PAD) begin
          it.rdata = cbrp_pkg::PAD_OPEN | {7'd0, pad_src[0]};
          shift_d  = {1'b1, pad_src[7:1]};
        end
      end else begin
        it.route = cbrp_pkg::ROUTE_CART;
        it.daddr = ra;
      end
      if (dma_rd) begin
        wphase_d = 1'b1;
        if (it.route == cbrp_pkg::ROUTE_INT) begin
          ext_d = 1'b0;
          if (ra_ram) begin
            it.dma_cap = 1'b1;
          end else begin
            byte_d = it.rdata;
          end
        end else begin
          ext_d = 1'b1;
        end
      end
    end else if (do_write) begin
      if (wa_ram) begin
        it.route = cbrp_pkg::ROUTE_INT;
      end else if (wa_ppu) begin
        it.route  = cbrp_pkg::ROUTE_PPU;
        it.daddr  = cbrp_pkg::PPU_BASE | {13'd0, addr_i[2:0]};
        it.dwdata = wdata_i;
        it.dwrite = 1'b1;
      end else if (addr_i == cbrp_pkg::ADDR_OAM_DMA) begin
        it.route = cbrp_pkg::ROUTE_INT;
        active_d = 1'b1;
        wphase_d = 1'b0;
        src_d    = {wdata_i, 8'd0};
      end else if (addr_i == cbrp_pkg::ADDR_PAD) begin
        it.route = cbrp_pkg::ROUTE_INT;
        strobe_d = wdata_i[0];
        if (wdata_i[0]) begin
          shift_d = buttons_i;
        end
      end else if (wa_io) begin
        it.route = cbrp_pkg::ROUTE_NONE;
      end else begin
        it.route  = cbrp_pkg::ROUTE_CART;
        it.daddr  = addr_i;
        it.dwdata = wdata_i;
        it.dwrite = 1'b1;
      end
    end else if (dma_wr) begin
      it.route  = cbrp_pkg::ROUTE_OAM;
      it.dwdata = oam_byte;
      it.dwrite = 1'b1;
      byte_d    = oam_byte;
      ext_d     = 1'b0;
      src_d     = src_inc;
      wphase_d  = 1'b0;
      if (src_inc[7:0] == 8'd0) begin
        active_d = 1'b0;
        it.done  = 1'b1;
      end
    end
    it.busy = active_d;
  end

  assign item_o = it;

  // Clear sweep after reset; the RAM has no per-entry valid bits.
  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + AW'(1);
      if (clr_idx_q == AW'(RAM_BYTES - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  assign clr_o       = clr_q;
  assign ram_we_o    = clr_q || (accept_i && do_write && wa_ram);
  assign ram_waddr_o = clr_q ? clr_idx_q : ram_index(addr_i[12:0]);
  assign ram_wdata_o = clr_q ? 8'd0 : wdata_i;
  assign ram_re_o    = accept_i && do_read && ra_ram;
  assign ram_raddr_o = ram_index(ra[12:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      shift_q  <= 8'd0;
      active_q <= 1'b0;
      wphase_q <= 1'b0;
      src_q    <= 16'd0;
      byte_q   <= 8'd0;
      ext_q    <= 1'b0;
    end else begin
      if (accept_i) begin
        strobe_q <= strobe_d;
        shift_q  <= shift_d;
        active_q <= active_d;
        wphase_q <= wphase_d;
        src_q    <= src_d;
        byte_q   <= byte_d;
        ext_q    <= ext_d;
      end else if (cap_i) begin
        byte_q <= ram_rdata_i;
      end
    end
  end

endmodule

[rtl/console_cpu_bus_with_ram_pad_dma_core.sv]
`timescale 1ns / 1ps
// Accepted transactions pass through registers s1_q and out_q to the master side.
// Throughput: one transaction per cycle unless out_q stalls or the RAM clears; the
// work RAM read is registered. RAM writes land at accept, so the next transaction
// already reads the new byte. Reset: rst_ni clears all control state, then RAM
// entries 0 to RAM_BYTES-1 clear with s_axis_tready low before any transaction.

module console_cpu_bus_with_ram_pad_dma_core #(
  parameter int RAM_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // addr, wdata, buttons, dev_rdata
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_data, dev_addr, dev_wdata, dev_write,
                                      // dma_busy, dma_done
  output logic [2:0]  m_axis_tuser    // route
);

  localparam int AW = $clog2(RAM_BYTES);

  logic            accept, clr, cap, s1_move;
  logic            s1_v_q, out_v_q;
  cbrp_pkg::item_t item, s1_q, out_q, s1_res;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  assign s1_move       = !out_v_q || m_axis_tready;
  assign s_axis_tready = !clr && (!s1_v_q || s1_move);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cap           = s1_v_q && s1_move && s1_q.dma_cap;

  cbrp_front #(
    .RAM_BYTES (RAM_BYTES),
    .AW        (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (s_axis_tuser),
    .addr_i      (s_axis_tdata[15:0]),
    .wdata_i     (s_axis_tdata[23:16]),
    .buttons_i   (s_axis_tdata[31:24]),
    .dev_rdata_i (s_axis_tdata[39:32]),
    .cap_i       (cap),
    .ram_rdata_i (ram_rdata),
    .clr_o       (clr),
    .item_o      (item),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  cbrp_ram #(
    .DEPTH (RAM_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Merge the RAM read data into the stage-one result.
  always_comb begin
    s1_res         = s1_q;
    s1_res.use_ram = 1'b0;
    s1_res.dma_cap = 1'b0;
    if (s1_q.use_ram) begin
      s1_res.rdata = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_move) begin
        out_v_q <= s1_v_q;
      end
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item;
    end
    if (s1_move && s1_v_q) begin
      out_q <= s1_res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.route;
  assign m_axis_tdata  = {5'd0, out_q.done, out_q.busy, out_q.dwrite, out_q.dwdata,
                          out_q.daddr, out_q.rdata};

  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |-> !s_axis_tready)
    else $error("transaction accepted during RAM clear");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_move) |-> !s_axis_tready)
    else $error("input taken while stage one is stalled");

  a_done_is_oam : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.done) |-> (out_q.route == cbrp_pkg::ROUTE_OAM && !out_q.busy))
    else $error("dma_done without final OAM write");

  a_stage_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_move) |=> out_v_q)
    else $error("stage-one result lost");

endmodule
